/* rtl/bilinear_image_scaler_unit_assert.svh */
// Assertion macros shared by the scaler checker.
`ifndef BILINEAR_IMAGE_SCALER_UNIT_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_UNIT_ASSERT_SVH

// Check a property while out of reset.
`define BIS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bilinear scaler check failed");

// Check a property at every edge, reset included.
`define BIS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("bilinear scaler check failed");

`endif

/* rtl/bis_pkg.sv */
// Types and constants of the bilinear image scaler.
`timescale 1ns / 1ps
package bis_pkg;

    localparam int COORD_W = 12;
    localparam int STEP_W  = 24;
    localparam int SIZE_W  = 9;
    localparam int IDX_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_INTERP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 2'd3;

    localparam logic [SIZE_W-1:0] RST_SRC_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT = 9'd256;
    localparam logic [STEP_W-1:0] RST_STEP       = 24'd65536;

    typedef logic [31:0] t_pixel;

    typedef struct packed {
        logic               opcode;
        logic [IDX_W-1:0]   pixel_index;
        logic [7:0]         in_blue;
        logic [7:0]         in_green;
        logic [7:0]         in_red;
        logic [7:0]         in_alpha;
        logic [COORD_W-1:0] dest_col;
        logic [COORD_W-1:0] dest_row;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
    } t_out_item;

endpackage

/* rtl/bis_ram.sv */
// Synchronous pixel memory, one write and one registered read port.
`timescale 1ns / 1ps
module bis_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  bis_pkg::t_pixel   i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output bis_pkg::t_pixel   o_rdata
);

    bis_pkg::t_pixel r_mem [0:DEPTH-1];
    bis_pkg::t_pixel r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_en && i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bis_addr.sv */
// Source position, edge clamping and neighbor addresses (three stages).
`timescale 1ns / 1ps
module bis_addr #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [bis_pkg::COORD_W-1:0]       i_col,
    input  logic [bis_pkg::COORD_W-1:0]       i_row,
    input  logic [bis_pkg::SIZE_W-1:0]        i_src_width,
    input  logic [bis_pkg::SIZE_W-1:0]        i_src_height,
    input  logic [bis_pkg::STEP_W-1:0]        i_x_step,
    input  logic [bis_pkg::STEP_W-1:0]        i_y_step,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] o_addr_tl,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] o_addr_tr,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] o_addr_bl,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] o_addr_br,
    output logic [FRAC_BITS-1:0]              o_fx,
    output logic [FRAC_BITS-1:0]              o_fy
);

    localparam int AW  = $clog2(MAX_WIDTH*MAX_HEIGHT);
    localparam int PW  = bis_pkg::COORD_W + bis_pkg::STEP_W;
    localparam int IW  = PW - FRAC_BITS;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RH  = $clog2(MAX_HEIGHT);
    localparam int SW  = $clog2(MAX_WIDTH+1);
    localparam int PRW = RH + SW;

    logic [IW-1:0] w_ext, h_ext, w_eff, h_eff;
    logic [IW-1:0] xi, yi, bxf, byf, nxf, nyf;
    logic [PW-1:0] r_xpos, r_ypos;
    logic [CW-1:0] r_bx, r_nx;
    logic [RH-1:0] r_by, r_ny;
    logic [FRAC_BITS-1:0] r_fx2, r_fy2, r_fx3, r_fy3;
    logic [AW-1:0] r_tl, r_tr, r_bl, r_br;
    logic [PRW-1:0] w_s, row0, row1;

    // Effective size: zero acts as one, oversize clamps to the store.
    always_comb begin
        w_ext = IW'(i_src_width);
        h_ext = IW'(i_src_height);
        if (w_ext == '0) begin
            w_eff = IW'(1);
        end else if (w_ext > IW'(MAX_WIDTH)) begin
            w_eff = IW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext == '0) begin
            h_eff = IW'(1);
        end else if (h_ext > IW'(MAX_HEIGHT)) begin
            h_eff = IW'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
    end

    always_comb begin
        xi  = r_xpos[PW-1:FRAC_BITS];
        yi  = r_ypos[PW-1:FRAC_BITS];
        bxf = (xi >= w_eff) ? (w_eff - IW'(1)) : xi;
        byf = (yi >= h_eff) ? (h_eff - IW'(1)) : yi;
        nxf = ((bxf + IW'(1)) < w_eff) ? (bxf + IW'(1)) : bxf;
        nyf = ((byf + IW'(1)) < h_eff) ? (byf + IW'(1)) : byf;
        w_s  = PRW'(w_eff);
        row0 = PRW'(r_by) * w_s;
        row1 = PRW'(r_ny) * w_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xpos <= PW'(i_col) * PW'(i_x_step);
            r_ypos <= PW'(i_row) * PW'(i_y_step);
            r_bx   <= CW'(bxf);
            r_nx   <= CW'(nxf);
            r_by   <= RH'(byf);
            r_ny   <= RH'(nyf);
            r_fx2  <= r_xpos[FRAC_BITS-1:0];
            r_fy2  <= r_ypos[FRAC_BITS-1:0];
            r_tl   <= AW'(row0 + PRW'(r_bx));
            r_tr   <= AW'(row0 + PRW'(r_nx));
            r_bl   <= AW'(row1 + PRW'(r_bx));
            r_br   <= AW'(row1 + PRW'(r_nx));
            r_fx3  <= r_fx2;
            r_fy3  <= r_fy2;
        end
    end

    assign o_addr_tl = r_tl;
    assign o_addr_tr = r_tr;
    assign o_addr_bl = r_bl;
    assign o_addr_br = r_br;
    assign o_fx = r_fx3;
    assign o_fy = r_fy3;

endmodule

/* rtl/bis_blend.sv */
// Two-stage bilinear blend of four RGBA neighbors.
`timescale 1ns / 1ps
module bis_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  bis_pkg::t_pixel       i_tl,
    input  bis_pkg::t_pixel       i_tr,
    input  bis_pkg::t_pixel       i_bl,
    input  bis_pkg::t_pixel       i_br,
    input  logic [FRAC_BITS-1:0]  i_fx,
    input  logic [FRAC_BITS-1:0]  i_fy,
    output bis_pkg::t_out_item    o_result
);

    localparam int TW  = FRAC_BITS + 9;
    localparam int SUW = 2*FRAC_BITS + 9;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [FRAC_BITS:0] wx0, wx1, wy0, wy1;
    logic [TW-1:0]  n_top [4];
    logic [TW-1:0]  n_bot [4];
    logic [TW-1:0]  r_top [4];
    logic [TW-1:0]  r_bot [4];
    logic [SUW-1:0] sum   [4];
    logic [7:0]     r_ch  [4];
    logic [FRAC_BITS-1:0] r_fy;

    always_comb begin
        wx1 = {1'b0, i_fx};
        wx0 = ONE - wx1;
        wy1 = {1'b0, r_fy};
        wy0 = ONE - wy1;
        for (int c = 0; c < 4; c++) begin
            n_top[c] = TW'(i_tl[8*c +: 8]) * TW'(wx0) + TW'(i_tr[8*c +: 8]) * TW'(wx1);
            n_bot[c] = TW'(i_bl[8*c +: 8]) * TW'(wx0) + TW'(i_br[8*c +: 8]) * TW'(wx1);
            sum[c]   = SUW'(r_top[c]) * SUW'(wy0) + SUW'(r_bot[c]) * SUW'(wy1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fy <= i_fy;
            for (int c = 0; c < 4; c++) begin
                r_top[c] <= n_top[c];
                r_bot[c] <= n_bot[c];
                r_ch[c]  <= sum[c][2*FRAC_BITS +: 8];
            end
        end
    end

    always_comb begin
        o_result.out_blue  = r_ch[0];
        o_result.out_green = r_ch[1];
        o_result.out_red   = r_ch[2];
        o_result.out_alpha = r_ch[3];
    end

endmodule

/* rtl/bilinear_image_scaler_unit.sv */
// Top level of the bilinear image scaler.
//
//  channel   direction  handshake             payload
//  item in   input      i_valid / o_stall     i_item   (bis_pkg::t_in_item)
//  item out  output     o_valid / i_stall     o_result (bis_pkg::t_out_item)
//  config    input      i_cfg_we              i_cfg_index, i_cfg_data
//
// One item enters per cycle while o_stall is low. An interpolate item leaves
// after passing the three address stages, the registered memory read and
// the two blend stages. Write items travel the same pipe and
// reach the memory at the read stage, so reads and writes stay in order.
// Reset clears the valid pipe and the configuration registers; pixel memory is not cleared.
// A stalled result freezes the whole pipe and raises o_stall.
`timescale 1ns / 1ps
module bilinear_image_scaler_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  bis_pkg::t_in_item                   i_item,
    output logic                                o_valid,
    input  logic                                i_stall,
    output bis_pkg::t_out_item                  o_result,
    input  logic                                i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic en, acc;
    logic [bis_pkg::SIZE_W-1:0] r_src_width, r_src_height;
    logic [bis_pkg::STEP_W-1:0] r_x_step, r_y_step;

    // Pipe control: interpolate valid per stage, write valid up to the memory.
    logic r_iv1, r_iv2, r_iv3, r_iv4, r_iv5, r_iv6;
    logic r_wv1, r_wv2, r_wv3;
    logic [AW-1:0] r_widx1, r_widx2, r_widx3;
    bis_pkg::t_pixel r_wdata1, r_wdata2, r_wdata3;
    logic [FRAC_BITS-1:0] r_fx4, r_fy4;

    logic [AW-1:0] addr_tl, addr_tr, addr_bl, addr_br;
    logic [FRAC_BITS-1:0] fx3, fy3;
    bis_pkg::t_pixel pix_tl, pix_tr, pix_bl, pix_br;

    // Advance everything unless a finished result is held back.
    assign en      = !(r_iv6 && i_stall);
    assign o_stall = !en;
    assign acc     = i_valid && en;
    assign o_valid = r_iv6;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= bis_pkg::RST_SRC_WIDTH;
            r_src_height <= bis_pkg::RST_SRC_HEIGHT;
            r_x_step     <= bis_pkg::RST_STEP;
            r_y_step     <= bis_pkg::RST_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bis_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[bis_pkg::SIZE_W-1:0];
                bis_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[bis_pkg::SIZE_W-1:0];
                bis_pkg::CFG_X_STEP:     r_x_step     <= i_cfg_data;
                bis_pkg::CFG_Y_STEP:     r_y_step     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid pipe; drop writes beyond the store at the door.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv1 <= 1'b0; r_iv2 <= 1'b0; r_iv3 <= 1'b0;
            r_iv4 <= 1'b0; r_iv5 <= 1'b0; r_iv6 <= 1'b0;
            r_wv1 <= 1'b0; r_wv2 <= 1'b0; r_wv3 <= 1'b0;
        end else if (en) begin
            r_iv1 <= acc && (i_item.opcode == bis_pkg::OP_INTERP);
            r_wv1 <= acc && (i_item.opcode == bis_pkg::OP_WRITE)
                     && (32'(i_item.pixel_index) < 32'(DEPTH));
            r_iv2 <= r_iv1; r_iv3 <= r_iv2; r_iv4 <= r_iv3;
            r_iv5 <= r_iv4; r_iv6 <= r_iv5;
            r_wv2 <= r_wv1; r_wv3 <= r_wv2;
        end
    end

    // Write payload rides along to the memory stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_widx1  <= AW'(i_item.pixel_index);
            r_wdata1 <= {i_item.in_alpha, i_item.in_red, i_item.in_green, i_item.in_blue};
            r_widx2  <= r_widx1;
            r_wdata2 <= r_wdata1;
            r_widx3  <= r_widx2;
            r_wdata3 <= r_wdata2;
            r_fx4    <= fx3;
            r_fy4    <= fy3;
        end
    end

    bis_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_addr (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_col        (i_item.dest_col),
        .i_row        (i_item.dest_row),
        .i_src_width  (r_src_width),
        .i_src_height (r_src_height),
        .i_x_step     (r_x_step),
        .i_y_step     (r_y_step),
        .o_addr_tl    (addr_tl),
        .o_addr_tr    (addr_tr),
        .o_addr_bl    (addr_bl),
        .o_addr_br    (addr_br),
        .o_fx         (fx3),
        .o_fy         (fy3)
    );

    // Four copies of the pixel store, one per neighbor, written together.
    bis_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_tl (
        .i_clk(i_clk), .i_en(en), .i_we(r_wv3), .i_waddr(r_widx3), .i_wdata(r_wdata3),
        .i_re(r_iv3), .i_raddr(addr_tl), .o_rdata(pix_tl)
    );
    bis_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_tr (
        .i_clk(i_clk), .i_en(en), .i_we(r_wv3), .i_waddr(r_widx3), .i_wdata(r_wdata3),
        .i_re(r_iv3), .i_raddr(addr_tr), .o_rdata(pix_tr)
    );
    bis_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_bl (
        .i_clk(i_clk), .i_en(en), .i_we(r_wv3), .i_waddr(r_widx3), .i_wdata(r_wdata3),
        .i_re(r_iv3), .i_raddr(addr_bl), .o_rdata(pix_bl)
    );
    bis_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_br (
        .i_clk(i_clk), .i_en(en), .i_we(r_wv3), .i_waddr(r_widx3), .i_wdata(r_wdata3),
        .i_re(r_iv3), .i_raddr(addr_br), .o_rdata(pix_br)
    );

    bis_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_tl     (pix_tl),
        .i_tr     (pix_tr),
        .i_bl     (pix_bl),
        .i_br     (pix_br),
        .i_fx     (r_fx4),
        .i_fy     (r_fy4),
        .o_result (o_result)
    );

endmodule

/* rtl/bis_checker.sv */
// Port-level checks of the scaler, bound to the top level.
`timescale 1ns / 1ps
`include "bilinear_image_scaler_unit_assert.svh"
module bis_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  bis_pkg::t_in_item                   i_item,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  bis_pkg::t_out_item                  o_result
);

    `BIS_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_valid)
    `BIS_ASSERT(a_stall_only_held, o_stall == (o_valid && i_stall))
    `BIS_ASSERT(a_out_hold, (o_valid && i_stall) |=> (o_valid && $stable(o_result)))
    `BIS_ASSERT(a_in_hold, (i_valid && o_stall) |=> (i_valid && $stable(i_item)))

endmodule

bind bilinear_image_scaler_unit bis_checker u_bis_checker (.*);

/* test/tb_bilinear_image_scaler_unit.sv */
// Self-checking bench for the bilinear image scaler: pixel loads and interpolation vs. a model.
`timescale 1ns / 1ps
module tb_bilinear_image_scaler_unit;

    localparam int MAX_W = 256;
    localparam int MAX_H = 256;
    localparam int FRAC  = 16;
    localparam int DEPTH = MAX_W * MAX_H;
    localparam int LATENCY = 6;
    localparam int WATCHDOG_LIMIT = 20000;

    // Scoreboard: keeps its own copy of the source image and the registers,
    // predicts each blended pixel and compares results in order.
    class scaler_scoreboard;
        bis_pkg::t_pixel   image_mem [DEPTH];
        bit                written   [DEPTH];
        logic [8:0]        src_w, src_h;
        logic [23:0]       step_x, step_y;
        bis_pkg::t_out_item pending [$];
        int                mismatches;

        function new();
            src_w = bis_pkg::RST_SRC_WIDTH;
            src_h = bis_pkg::RST_SRC_HEIGHT;
            step_x = bis_pkg::RST_STEP;
            step_y = bis_pkg::RST_STEP;
            mismatches = 0;
            foreach (written[i]) written[i] = 0;
        endfunction

        function void set_reg(logic [bis_pkg::CFG_IDX_W-1:0] idx,
                              logic [bis_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                bis_pkg::CFG_SRC_WIDTH:  src_w = val[8:0];
                bis_pkg::CFG_SRC_HEIGHT: src_h = val[8:0];
                bis_pkg::CFG_X_STEP:     step_x = val;
                bis_pkg::CFG_Y_STEP:     step_y = val;
                default: ;
            endcase
        endfunction

        function int eff_size(logic [8:0] v, int maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        // Neighbour addresses of one destination pixel; also used to keep the
        // stimulus away from unwritten entries.
        function void neighbours(logic [11:0] col, logic [11:0] row,
                                 output int addr[4], output longint fx, output longint fy);
            longint xp, yp, xi, yi;
            int w, h, bx, by, nx, ny;
            w = eff_size(src_w, MAX_W);
            h = eff_size(src_h, MAX_H);
            xp = longint'(col) * longint'(step_x);
            yp = longint'(row) * longint'(step_y);
            xi = xp >> FRAC;
            yi = yp >> FRAC;
            fx = xp & ((64'd1 << FRAC) - 1);
            fy = yp & ((64'd1 << FRAC) - 1);
            bx = (xi >= w) ? w - 1 : int'(xi);
            by = (yi >= h) ? h - 1 : int'(yi);
            nx = (bx + 1 < w) ? bx + 1 : bx;
            ny = (by + 1 < h) ? by + 1 : by;
            addr[0] = (by * w + bx) % DEPTH;
            addr[1] = (by * w + nx) % DEPTH;
            addr[2] = (ny * w + bx) % DEPTH;
            addr[3] = (ny * w + nx) % DEPTH;
        endfunction

        function bit all_written(logic [11:0] col, logic [11:0] row);
            int a[4];
            longint fx, fy;
            neighbours(col, row, a, fx, fy);
            return written[a[0]] && written[a[1]] && written[a[2]] && written[a[3]];
        endfunction

        function void note_input(bis_pkg::t_in_item it);
            int a[4];
            longint fx, fy, one, top, bot, sum;
            logic [7:0] ch[4];
            bis_pkg::t_pixel p[4];
            bis_pkg::t_out_item r;
            if (it.opcode == bis_pkg::OP_WRITE) begin
                image_mem[it.pixel_index] = {it.in_alpha, it.in_red, it.in_green, it.in_blue};
                written[it.pixel_index] = 1;
                return;
            end
            neighbours(it.dest_col, it.dest_row, a, fx, fy);
            one = 64'd1 << FRAC;
            for (int k = 0; k < 4; k++) p[k] = image_mem[a[k]];
            for (int c = 0; c < 4; c++) begin
                top = longint'(p[0][8*c +: 8]) * (one - fx) + longint'(p[1][8*c +: 8]) * fx;
                bot = longint'(p[2][8*c +: 8]) * (one - fx) + longint'(p[3][8*c +: 8]) * fx;
                sum = top * (one - fy) + bot * fy;
                ch[c] = 8'(sum >> (2 * FRAC));
            end
            r.out_blue = ch[0];
            r.out_green = ch[1];
            r.out_red = ch[2];
            r.out_alpha = ch[3];
            pending.push_back(r);
        endfunction

        function void check_result(bis_pkg::t_out_item got);
            bis_pkg::t_out_item want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected pixel %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.out_blue !== want.out_blue || got.out_green !== want.out_green ||
                got.out_red !== want.out_red || got.out_alpha !== want.out_alpha) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel mismatch: expected %h got %h", want, got);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, i_stall, i_cfg_we;
    logic o_stall, o_valid;
    bis_pkg::t_in_item  i_item;
    bis_pkg::t_out_item o_result;
    logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data;

    scaler_scoreboard sb;
    int send_idle_pct, stall_pct;
    int idle_cycles;
    bit timed_out;
    bit valid_q;

    bilinear_image_scaler_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Sample results and acceptances at the edge; predict on acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_result(o_result);
            if (i_valid && !o_stall) sb.note_input(i_item);
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver stall pattern, redrawn every cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 0;
        else i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Drop valid once; valid_q tracks the value already scheduled.
    task automatic drop_valid();
        if (valid_q) begin
            i_valid <= 1'b0;
            valid_q = 0;
        end
    endtask

    // Hand one item to the block and hold it until accepted.
    task automatic send_item(bis_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            drop_valid();
            @(posedge i_clk);
        end
        i_item <= it;
        if (!valid_q) begin
            i_valid <= 1'b1;
            valid_q = 1;
        end
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic write_pixel(int idx);
        bis_pkg::t_in_item it;
        it = '0;
        it.opcode = bis_pkg::OP_WRITE;
        it.pixel_index = bis_pkg::IDX_W'(idx);
        {it.in_alpha, it.in_red, it.in_green, it.in_blue} = $urandom;
        it.dest_col = bis_pkg::COORD_W'($urandom);
        it.dest_row = bis_pkg::COORD_W'($urandom);
        send_item(it);
    endtask

    // Interpolate only where every neighbour has been loaded.
    task automatic interp(logic [11:0] col, logic [11:0] row);
        bis_pkg::t_in_item it;
        if (!sb.all_written(col, row)) begin
            drop_valid();
            return;
        end
        it = '0;
        it.opcode = bis_pkg::OP_INTERP;
        {it.in_alpha, it.in_red, it.in_green, it.in_blue} = $urandom;
        it.pixel_index = bis_pkg::IDX_W'($urandom);
        it.dest_col = col;
        it.dest_row = row;
        send_item(it);
    endtask

    // Drain, then let the pipe empty before touching registers.
    task automatic drain();
        drop_valid();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [bis_pkg::CFG_IDX_W-1:0] idx,
                             logic [bis_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic setup(int w, int h, int sx, int sy);
        drain();
        write_reg(bis_pkg::CFG_SRC_WIDTH, bis_pkg::CFG_DATA_W'(w));
        write_reg(bis_pkg::CFG_SRC_HEIGHT, bis_pkg::CFG_DATA_W'(h));
        write_reg(bis_pkg::CFG_X_STEP, bis_pkg::CFG_DATA_W'(sx));
        write_reg(bis_pkg::CFG_Y_STEP, bis_pkg::CFG_DATA_W'(sy));
        i_cfg_we <= 1'b0;
    endtask

    // Load a whole w x h image (effective sizes) so any read is defined.
    task automatic load_image(int w, int h);
        for (int i = 0; i < w * h; i++) write_pixel(i);
    endtask

    task automatic random_phase(int n, int w, int h);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) write_pixel($urandom_range(w * h - 1));
            else if ($urandom_range(9) == 0) write_pixel($urandom_range(65535));
            else interp(bis_pkg::COORD_W'($urandom), bis_pkg::COORD_W'($urandom));
        end
    endtask

    initial begin
        int w, h;
        sb = new();
        timed_out = 0;
        valid_q = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_item = '0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: tiny image, edges, saturation, zero and oversize sizes.
        setup(4, 3, 24'h00C000, 24'h008000);
        load_image(4, 3);
        write_pixel(0); // rewrite a corner with fresh data
        interp(0, 0);
        interp(5, 5);
        interp(12'hFFF, 12'hFFF);
        interp(3, 0);
        interp(0, 2);
        setup(0, 0, 24'hFFFFFF, 0);
        interp(12'hFFF, 0);
        interp(1, 12'hFFF);
        setup(9'h1FF, 2, 24'h000001, 24'hFFFFFF);
        load_image(256, 2);
        interp(12'hFFF, 1);
        interp(0, 12'hFFF);
        interp(12'h800, 12'h001);
        drain();
        send_idle_pct = 0;
        write_pixel(65535);
        drain();

        // Random phases with different sizes, steps and handshake pressure.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 16);
            setup(w, h, $urandom_range(24'hFFFFFF) & (ph[0] ? 24'h03FFFF : 24'hFFFFFF),
                  $urandom_range(24'h03FFFF));
            load_image(w, h);
            random_phase(80, w, h);
        end
        stall_pct = 0;
        setup(bis_pkg::RST_SRC_WIDTH, bis_pkg::RST_SRC_HEIGHT, bis_pkg::RST_STEP,
              bis_pkg::RST_STEP);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
